// ----- rtl/core/esst_pkg.sv -----
// Package with the shared types, constants and helpers of the encoder settings block.
package esst_pkg;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 96;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam int unsigned DIV_NUM_W = 36;
    localparam int unsigned DIV_DEN_W = 23;
    localparam int unsigned MUL_A_W   = 26;
    localparam int unsigned MUL_B_W   = 16;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_STROKE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSP_SUB    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_SUB     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd3;

    localparam logic [15:0] FULL_STROKE_RST = 16'd440;
    localparam logic [19:0] INSP_SUB_RST    = 20'd30000;
    localparam logic [13:0] EXP_SUB_RST     = 14'd0;
    localparam logic [15:0] DEBOUNCE_RST    = 16'd120;

    localparam logic [5:0] RATE_MIN  = 6'd6;
    localparam logic [5:0] RATE_MAX  = 6'd40;
    localparam logic [6:0] VOL_MIN   = 7'd10;
    localparam logic [6:0] VOL_MAX   = 7'd100;
    localparam logic [2:0] RATIO_MAX = 3'd4;

    localparam logic [1:0] SEL_RATE   = 2'd0;
    localparam logic [1:0] SEL_VOLUME = 2'd1;
    localparam logic [1:0] SEL_RATIO  = 2'd2;

    localparam logic [MUL_A_W-1:0]   US_PER_MIN  = 26'd60000000;
    localparam logic [MUL_A_W-1:0]   MS_PER_MIN  = 26'd60000;
    localparam logic [MUL_A_W-1:0]   US_PER_S    = 26'd1000000;
    localparam logic [DIV_DEN_W-1:0] PERCENT_DIV = 23'd100;

    typedef struct packed {
        logic [15:0] full_stroke;
        logic [19:0] insp_sub;
        logic [13:0] exp_sub;
        logic [15:0] debounce;
    } t_cfg;

    typedef struct packed {
        logic [5:0] rate;
        logic [6:0] volume;
        logic [1:0] insp;
        logic [2:0] expf;
    } t_set;

    typedef struct packed {
        logic [15:0] steps;
        logic [22:0] t_in;
        logic [13:0] t_ex;
        logic [15:0] srate;
    } t_derived;

    typedef struct packed {
        logic [1:0] insp;
        logic [2:0] expf;
    } t_ratio;

    function automatic t_ratio esst_ratio(input logic [2:0] idx);
        t_ratio r;
        if (idx == 3'd0) begin
            r.insp = 2'd2;
            r.expf = 3'd1;
        end else begin
            r.insp = 2'd1;
            r.expf = idx + 3'd1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/esst_div.sv -----
// Restoring divider, one quotient bit per cycle.
module esst_div import esst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

    logic                 r_run;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    assign rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            r_num <= {r_num[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ----- rtl/core/esst_calc.sv -----
// Sequencer that recomputes stroke steps, times and step rate on the shared divider.
module esst_calc import esst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_cfg     i_cfg,
    input  t_set     i_set,
    output logic     o_busy,
    output logic     o_done,
    output t_derived o_der
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DEN   = 5'b00010,
        S_MUL   = 5'b00100,
        S_START = 5'b01000,
        S_WAIT  = 5'b10000
    } t_cstate;

    localparam logic [1:0] PH_STEPS = 2'd0;
    localparam logic [1:0] PH_TIN   = 2'd1;
    localparam logic [1:0] PH_TEX   = 2'd2;
    localparam logic [1:0] PH_RATE  = 2'd3;

    t_cstate              r_state;
    logic [1:0]           r_phase;
    logic                 r_done;
    logic [7:0]           r_den;
    logic [DIV_NUM_W-1:0] r_prod;
    t_derived             r_der;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [5:0]           rate_g;
    logic [2:0]           sum_g;
    logic                 div_start;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_NUM_W-1:0] sub_in;
    logic [DIV_NUM_W-1:0] sub_ex;
    logic [DIV_NUM_W-1:0] diff_in;
    logic [DIV_NUM_W-1:0] diff_ex;
    logic [15:0]          quot_sat;

    assign rate_g = (i_set.rate == 6'd0) ? 6'd1 : i_set.rate;
    assign sum_g  = ({1'b0, i_set.insp} + i_set.expf == 3'd0) ? 3'd1
                    : ({1'b0, i_set.insp} + i_set.expf);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_DEN) begin
            mul_a = MUL_A_W'(rate_g);
            mul_b = MUL_B_W'(sum_g);
        end else begin
            unique case (r_phase)
                PH_STEPS: begin
                    mul_a = MUL_A_W'(i_cfg.full_stroke);
                    mul_b = MUL_B_W'(i_set.volume);
                end
                PH_TIN: begin
                    mul_a = US_PER_MIN;
                    mul_b = MUL_B_W'(i_set.insp);
                end
                PH_TEX: begin
                    mul_a = MS_PER_MIN;
                    mul_b = MUL_B_W'(i_set.expf);
                end
                default: begin
                    mul_a = US_PER_S;
                    mul_b = r_der.steps;
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (r_phase)
            PH_STEPS:       div_den = PERCENT_DIV;
            PH_TIN, PH_TEX: div_den = DIV_DEN_W'(r_den);
            default:        div_den = r_der.t_in;
        endcase
    end

    assign div_start = (r_state == S_START) && !(r_phase == PH_RATE && r_der.t_in == '0);

    assign sub_in   = DIV_NUM_W'(i_cfg.insp_sub);
    assign sub_ex   = DIV_NUM_W'(i_cfg.exp_sub);
    assign diff_in  = (div_quot > sub_in) ? div_quot - sub_in : '0;
    assign diff_ex  = (div_quot > sub_ex) ? div_quot - sub_ex : '0;
    assign quot_sat = (|div_quot[DIV_NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];

    esst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_STEPS;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_state <= S_DEN;
                r_phase <= PH_STEPS;
            end else begin
                unique case (r_state)
                    S_IDLE: r_state <= S_IDLE;
                    S_DEN:  r_state <= S_MUL;
                    S_MUL:  r_state <= S_START;
                    S_START: begin
                        if (div_start) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end
                    end
                    S_WAIT: begin
                        if (div_done) begin
                            if (r_phase == PH_RATE) begin
                                r_state <= S_IDLE;
                                r_done  <= 1'b1;
                            end else begin
                                r_phase <= r_phase + 2'd1;
                                r_state <= S_MUL;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DEN) begin
            r_den <= mul_p[7:0];
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_p[DIV_NUM_W-1:0];
        end
        if (r_state == S_START && !div_start && !i_start) begin
            r_der.srate <= 16'hFFFF;
        end
        if (r_state == S_WAIT && div_done && !i_start) begin
            unique case (r_phase)
                PH_STEPS: r_der.steps <= quot_sat;
                PH_TIN:   r_der.t_in  <= diff_in[22:0];
                PH_TEX:   r_der.t_ex  <= diff_ex[13:0];
                default:  r_der.srate <= quot_sat;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_der  = r_der;

endmodule

// ----- rtl/core/encoder_settings_and_stroke_timing.sv -----
// Encoder settings editor with stroke timing recompute, top level.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: enc_a, enc_b, enc_button, now_ms, edit_enable
//  m_*      out  m_tvalid/m_tready  m_tdata: settings, derived values, settings_changed
//  i_cfg_*  in   i_cfg_wen          i_cfg_idx, i_cfg_wdata
//
// An item without a setting step is held pending, then loaded to the output register;
// one that steps a setting runs the recompute: a denominator product, then passes of
// the shared divider for steps, inspiration time, expiration time and step rate, one
// bit per cycle (no step-rate pass when the inspiration time is zero). A register write
// starts the same recompute; after reset it runs once before s_tready rises. One item
// is in work at a time; the output register holds a result while the next is taken.
module encoder_settings_and_stroke_timing import esst_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // enc_a, enc_b, enc_button, now_ms[31:0], edit_enable, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // selected_item[1:0], rate_per_min[5:0], volume_percent[6:0], insp_factor[1:0],
    // exp_factor[2:0], stroke_steps[15:0], insp_time_us[22:0], exp_time_ms[13:0],
    // step_rate[15:0], settings_changed, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    t_cfg       r_cfg;
    t_set       r_set, n_set;
    logic [1:0] r_sel, n_sel;
    logic       r_prev_btn, n_prev_btn;
    logic       r_prev_a, n_prev_a;
    logic [31:0] r_last, n_last;
    logic [2:0] r_ridx, n_ridx;
    logic       r_chg, n_chg;
    logic       r_boot;
    logic       r_wait;
    logic       r_pend;
    logic       r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic        in_a, in_b, in_btn, in_en;
    logic [31:0] in_now;
    logic [31:0] elapsed;
    logic        press, a_fall, up;
    logic        s_acc, m_acc, load;
    logic        calc_start, calc_busy, calc_done;
    t_derived    der;
    t_ratio      ratio_n;

    assign in_a   = s_tdata[0];
    assign in_b   = s_tdata[1];
    assign in_btn = s_tdata[2];
    assign in_now = s_tdata[34:3];
    assign in_en  = s_tdata[35];

    assign s_tready = !r_boot && !r_wait && !r_pend && !calc_busy;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = r_out_valid && m_tready;
    assign load     = r_pend && (!r_out_valid || m_tready);

    assign elapsed = in_now - r_last;
    assign press   = r_prev_btn && !in_btn && (elapsed > 32'(r_cfg.debounce));
    assign a_fall  = r_prev_a && !in_a;
    assign up      = in_b;
    assign ratio_n = esst_ratio(n_ridx);

    always_comb begin
        n_set      = r_set;
        n_sel      = r_sel;
        n_prev_btn = r_prev_btn;
        n_prev_a   = r_prev_a;
        n_last     = r_last;
        n_ridx     = r_ridx;
        n_chg      = r_chg;
        if (s_acc) begin
            n_chg = 1'b0;
            if (in_en) begin
                if (press) begin
                    n_last = in_now;
                    n_sel  = (r_sel < SEL_RATIO) ? r_sel + 2'd1 : SEL_RATE;
                end
                n_prev_btn = in_btn;
                n_prev_a   = in_a;
                if (a_fall) begin
                    n_chg = 1'b1;
                    unique case (n_sel)
                        SEL_RATE: begin
                            if (up && r_set.rate < RATE_MAX) begin
                                n_set.rate = r_set.rate + 6'd1;
                            end else if (!up && r_set.rate > RATE_MIN) begin
                                n_set.rate = r_set.rate - 6'd1;
                            end
                        end
                        SEL_VOLUME: begin
                            if (up && r_set.volume < VOL_MAX) begin
                                n_set.volume = r_set.volume + 7'd1;
                            end else if (!up && r_set.volume > VOL_MIN) begin
                                n_set.volume = r_set.volume - 7'd1;
                            end
                        end
                        SEL_RATIO: begin
                            if (up && r_ridx < RATIO_MAX) begin
                                n_ridx = r_ridx + 3'd1;
                            end else if (!up && r_ridx > 3'd0) begin
                                n_ridx = r_ridx - 3'd1;
                            end
                            n_set.insp = ratio_n.insp;
                            n_set.expf = ratio_n.expf;
                        end
                        default: n_set = r_set;
                    endcase
                end
            end
        end
    end

    assign calc_start = r_boot || i_cfg_wen || (s_acc && n_chg);

    esst_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_cfg   (r_cfg),
        .i_set   (r_set),
        .o_busy  (calc_busy),
        .o_done  (calc_done),
        .o_der   (der)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_stroke <= FULL_STROKE_RST;
            r_cfg.insp_sub    <= INSP_SUB_RST;
            r_cfg.exp_sub     <= EXP_SUB_RST;
            r_cfg.debounce    <= DEBOUNCE_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_FULL_STROKE: r_cfg.full_stroke <= i_cfg_wdata[15:0];
                CFG_INSP_SUB:    r_cfg.insp_sub    <= i_cfg_wdata[19:0];
                CFG_EXP_SUB:     r_cfg.exp_sub     <= i_cfg_wdata[13:0];
                CFG_DEBOUNCE:    r_cfg.debounce    <= i_cfg_wdata[15:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set.rate   <= RATE_MAX;
            r_set.volume <= VOL_MAX;
            r_set.insp   <= 2'd1;
            r_set.expf   <= 3'd2;
            r_sel        <= SEL_RATE;
            r_prev_btn   <= 1'b1;
            r_prev_a     <= 1'b1;
            r_last       <= '0;
            r_ridx       <= '0;
            r_chg        <= 1'b0;
            r_boot       <= 1'b1;
            r_wait       <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_set      <= n_set;
            r_sel      <= n_sel;
            r_prev_btn <= n_prev_btn;
            r_prev_a   <= n_prev_a;
            r_last     <= n_last;
            r_ridx     <= n_ridx;
            r_chg      <= n_chg;
            r_boot     <= 1'b0;
            if (s_acc) begin
                if (n_chg) begin
                    r_wait <= 1'b1;
                end else begin
                    r_pend <= 1'b1;
                end
            end else if (r_wait && calc_done) begin
                r_wait <= 1'b0;
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= {6'd0, r_chg, der.srate, der.t_ex, der.t_in, der.steps,
                           r_set.expf, r_set.insp, r_set.volume, r_set.rate, r_sel};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    a_hold_settings: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_acc |=> ($stable(r_set) && $stable(r_sel) && $stable(r_ridx)))
        else $error("settings moved without an input transaction");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (!calc_busy && !r_wait))
        else $error("result pending while recompute runs");

    a_wait_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait && calc_done) |=> (r_pend && !r_wait))
        else $error("recompute finish did not release the result");

    a_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_set.rate >= RATE_MIN) && (r_set.rate <= RATE_MAX) &&
        (r_set.volume >= VOL_MIN) && (r_set.volume <= VOL_MAX) && (r_ridx <= RATIO_MAX))
        else $error("setting outside its limits");

endmodule
